// ----- hdl/bvo_pkg.sv -----
// Shared types and constants for the bristle vertex offset block.
package bvo_pkg;

  // Square root steps (one result bit each) and divider steps (one quotient bit each)
  localparam int unsigned SQ_STEPS  = 32;
  localparam int unsigned DIV_STEPS = 32;
  // Front stages (multiply, max, lead one, shift, square, sum) and back stages
  localparam int unsigned FRONT_ST  = 6;
  localparam int unsigned BACK_ST   = 3;
  localparam int unsigned NST       = FRONT_ST + SQ_STEPS + DIV_STEPS + BACK_ST;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_INV_XY    = 2'd0,
    REG_INV_Z     = 2'd1,
    REG_TOP_LEN   = 2'd2,
    REG_UNDER_LEN = 2'd3
  } bvo_reg_e;

  typedef struct packed {
    logic signed [31:0] normal_x;
    logic signed [31:0] normal_y;
    logic signed [31:0] normal_z;
    logic signed [31:0] mid_x;
    logic signed [31:0] mid_y;
    logic signed [31:0] mid_z;
  } bvo_in_t;

  typedef struct packed {
    logic signed [31:0] vert_x;
    logic signed [31:0] vert_y;
    logic signed [31:0] vert_z;
    logic               is_under;
    logic               degenerate;
    logic               last;
  } bvo_out_t;

  typedef struct packed {
    logic [30:0] inv_xy;
    logic [30:0] inv_z;
    logic [31:0] top_len;
    logic [31:0] under_len;
  } bvo_cfg_t;

  // Data that rides along the arithmetic pipeline
  typedef struct packed {
    logic [2:0][31:0] mid;
    logic [2:0]       neg;
    logic             degen;
  } bvo_carry_t;

  // Both candidate vertices of one item
  typedef struct packed {
    logic [2:0][31:0] vt;
    logic [2:0][31:0] vu;
    logic             degen;
  } bvo_pair_t;

endpackage

// ----- hdl/bvo_core.sv -----
// Arithmetic pipeline: scaled normal, square root, division and both offset vertices.
module bvo_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 in_valid_i,
  input  bvo_pkg::bvo_in_t     in_data_i,
  input  bvo_pkg::bvo_cfg_t    cfg_i,
  output logic                 out_valid_o,
  output bvo_pkg::bvo_pair_t   out_data_o
);

  // Push a point along or against an offset, saturated to 32 bits
  function automatic logic [31:0] push(logic [31:0] mid, logic [47:0] off, logic neg);
    logic signed [49:0] m;
    logic signed [49:0] o;
    logic signed [49:0] s;
    m = {{18{mid[31]}}, mid};
    o = {2'b00, off};
    s = neg ? (m - o) : (m + o);
    if (s[49:31] != {19{s[49]}}) begin
      return s[49] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end
    return s[31:0];
  endfunction

  logic [bvo_pkg::NST-1:0] vld_q;
  logic [2:0][30:0]        inv;

  // Advance valid bits with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[bvo_pkg::NST-2:0], in_valid_i};
    end
  end

  assign inv = {cfg_i.inv_z, cfg_i.inv_xy, cfg_i.inv_xy};

  // Stage 1: magnitude times inverse scale
  logic [2:0][31:0]    nrm, absn;
  logic [2:0][61:0]    em1_d, em1_q;
  bvo_pkg::bvo_carry_t c1_d, c1_q;

  always_comb begin
    nrm      = {in_data_i.normal_z, in_data_i.normal_y, in_data_i.normal_x};
    c1_d.mid = {in_data_i.mid_z, in_data_i.mid_y, in_data_i.mid_x};
    c1_d.degen = 1'b0;
    for (int i = 0; i < 3; i++) begin
      c1_d.neg[i] = nrm[i][31];
      absn[i]     = nrm[i][31] ? (~nrm[i] + 32'd1) : nrm[i];
      em1_d[i]    = {30'd0, absn[i]} * {31'd0, inv[i]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      em1_q <= em1_d;
      c1_q  <= c1_d;
    end
  end

  // Stage 2: largest scaled component
  logic [61:0]         m01, a2_q;
  logic [2:0][61:0]    em2_q;
  bvo_pkg::bvo_carry_t c2_q;

  assign m01 = (em1_q[0] > em1_q[1]) ? em1_q[0] : em1_q[1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a2_q  <= (m01 > em1_q[2]) ? m01 : em1_q[2];
      em2_q <= em1_q;
      c2_q  <= c1_q;
    end
  end

  // Stage 3: leading one of the largest component
  logic [5:0]          p3_d, p3_q;
  logic [2:0][61:0]    em3_q;
  bvo_pkg::bvo_carry_t c3_d, c3_q;

  always_comb begin
    p3_d = '0;
    for (int j = 0; j < 62; j++) begin
      if (a2_q[j]) p3_d = 6'(j);
    end
    c3_d       = c2_q;
    c3_d.degen = (a2_q == '0);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p3_q  <= p3_d;
      em3_q <= em2_q;
      c3_q  <= c3_d;
    end
  end

  // Stage 4: common shift so the largest lands in [2^29, 2^30)
  logic [2:0][61:0]    sh4;
  logic [2:0][29:0]    f4_q;
  bvo_pkg::bvo_carry_t c4_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (p3_q > 6'd29) sh4[i] = em3_q[i] >> (p3_q - 6'd29);
      else              sh4[i] = em3_q[i] << (6'd29 - p3_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) f4_q[i] <= sh4[i][29:0];
      c4_q <= c3_q;
    end
  end

  // Stage 5: squares
  logic [2:0][59:0]    sq5_q;
  logic [2:0][29:0]    f5_q;
  bvo_pkg::bvo_carry_t c5_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) sq5_q[i] <= {30'd0, f4_q[i]} * {30'd0, f4_q[i]};
      f5_q <= f4_q;
      c5_q <= c4_q;
    end
  end

  // Stage 6: sum of squares
  logic [61:0]         q6_q;
  logic [2:0][29:0]    f6_q;
  bvo_pkg::bvo_carry_t c6_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      q6_q <= {2'b00, sq5_q[0]} + {2'b00, sq5_q[1]} + {2'b00, sq5_q[2]};
      f6_q <= f5_q;
      c6_q <= c5_q;
    end
  end

  // Square root, one result bit per stage
  logic [63:0]         sq_rem_q [bvo_pkg::SQ_STEPS];
  logic [63:0]         sq_res_q [bvo_pkg::SQ_STEPS];
  logic [2:0][29:0]    sq_f_q   [bvo_pkg::SQ_STEPS];
  bvo_pkg::bvo_carry_t sq_c_q   [bvo_pkg::SQ_STEPS];

  for (genvar k = 0; k < bvo_pkg::SQ_STEPS; k++) begin : g_sq
    logic [63:0]         rem_in, res_in, bitv, tst;
    logic [2:0][29:0]    f_in;
    bvo_pkg::bvo_carry_t c_in;

    if (k == 0) begin : g_first
      assign rem_in = {2'b00, q6_q};
      assign res_in = '0;
      assign f_in   = f6_q;
      assign c_in   = c6_q;
    end else begin : g_next
      assign rem_in = sq_rem_q[k-1];
      assign res_in = sq_res_q[k-1];
      assign f_in   = sq_f_q[k-1];
      assign c_in   = sq_c_q[k-1];
    end

    assign bitv = 64'd1 << (62 - 2 * k);
    assign tst  = res_in + bitv;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (rem_in >= tst) begin
          sq_rem_q[k] <= rem_in - tst;
          sq_res_q[k] <= (res_in >> 1) + bitv;
        end else begin
          sq_rem_q[k] <= rem_in;
          sq_res_q[k] <= res_in >> 1;
        end
        sq_f_q[k] <= f_in;
        sq_c_q[k] <= c_in;
      end
    end
  end

  // Division f * 2^31 / mag, three lanes, one quotient bit per stage
  logic [2:0][32:0]    dv_r_q   [bvo_pkg::DIV_STEPS];
  logic [2:0][31:0]    dv_w_q   [bvo_pkg::DIV_STEPS];
  logic [31:0]         dv_mag_q [bvo_pkg::DIV_STEPS];
  bvo_pkg::bvo_carry_t dv_c_q   [bvo_pkg::DIV_STEPS];

  for (genvar k = 0; k < bvo_pkg::DIV_STEPS; k++) begin : g_dv
    logic [2:0][32:0]    r_in, rs, r_out;
    logic [2:0][31:0]    w_in, w_out;
    logic [31:0]         mag_in;
    bvo_pkg::bvo_carry_t c_in;

    if (k == 0) begin : g_first
      for (genvar i = 0; i < 3; i++) begin : g_ln
        assign r_in[i] = {3'b000, sq_f_q[bvo_pkg::SQ_STEPS-1][i]};
        assign rs[i]   = r_in[i];
      end
      assign w_in   = '0;
      assign mag_in = sq_res_q[bvo_pkg::SQ_STEPS-1][31:0];
      assign c_in   = sq_c_q[bvo_pkg::SQ_STEPS-1];
    end else begin : g_next
      for (genvar i = 0; i < 3; i++) begin : g_ln
        assign r_in[i] = dv_r_q[k-1][i];
        assign rs[i]   = {r_in[i][31:0], 1'b0};
      end
      assign w_in   = dv_w_q[k-1];
      assign mag_in = dv_mag_q[k-1];
      assign c_in   = dv_c_q[k-1];
    end

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        if (rs[i] >= {1'b0, mag_in}) begin
          r_out[i] = rs[i] - {1'b0, mag_in};
          w_out[i] = {w_in[i][30:0], 1'b1};
        end else begin
          r_out[i] = rs[i];
          w_out[i] = {w_in[i][30:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        dv_r_q[k]   <= r_out;
        dv_w_q[k]   <= w_out;
        dv_mag_q[k] <= mag_in;
        dv_c_q[k]   <= c_in;
      end
    end
  end

  // Back stage 1: unit direction times inverse scale
  logic [2:0][62:0]    pu;
  logic [2:0][31:0]    u_q;
  bvo_pkg::bvo_carry_t cu_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pu[i] = {31'd0, dv_w_q[bvo_pkg::DIV_STEPS-1][i]} * {32'd0, inv[i]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        u_q[i] <= dv_c_q[bvo_pkg::DIV_STEPS-1].degen ? 32'd0 : pu[i][62:31];
      end
      cu_q <= dv_c_q[bvo_pkg::DIV_STEPS-1];
    end
  end

  // Back stage 2: offsets for both sides
  logic [31:0]         lt, lu;
  logic [2:0][63:0]    pt, pn;
  logic [2:0][47:0]    ot_q, ou_q;
  logic [2:0]          nt_q, nu_q;
  bvo_pkg::bvo_carry_t co_q;

  assign lt = cfg_i.top_len[31] ? (~cfg_i.top_len + 32'd1) : cfg_i.top_len;
  assign lu = cfg_i.under_len[31] ? (~cfg_i.under_len + 32'd1) : cfg_i.under_len;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pt[i] = {32'd0, u_q[i]} * {32'd0, lt};
      pn[i] = {32'd0, u_q[i]} * {32'd0, lu};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        ot_q[i] <= pt[i][63:16];
        ou_q[i] <= pn[i][63:16];
        nt_q[i] <= cu_q.neg[i] ^ cfg_i.top_len[31];
        nu_q[i] <= ~(cu_q.neg[i] ^ cfg_i.under_len[31]);
      end
      co_q <= cu_q;
    end
  end

  // Back stage 3: saturated vertices
  bvo_pkg::bvo_pair_t vp_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        vp_q.vt[i] <= push(co_q.mid[i], ot_q[i], nt_q[i]);
        vp_q.vu[i] <= push(co_q.mid[i], ou_q[i], nu_q[i]);
      end
      vp_q.degen <= co_q.degen;
    end
  end

  assign out_valid_o = vld_q[bvo_pkg::NST-1];
  assign out_data_o  = vp_q;

endmodule

// ----- hdl/bristle_vertex_offset_unit.sv -----
// Top level: configuration registers, skid stage and per-side result sequencer.
//
// Usage: write the four registers through cfg_we_i / cfg_idx_i / cfg_data_i while
// the block is idle (0 inverse xy scale, 1 inverse z scale, 2 top length,
// 3 under length). Items enter on in_valid_i / in_ready_o, one per cycle at most.
// Each item yields the top vertex when top length is nonzero, then the under
// vertex when under length is nonzero; last marks the final one, and an item
// with both lengths zero yields nothing.
// The arithmetic pipeline is 73 stages (six front stages, 32 square root
// steps, 32 divider steps, three offset stages), followed by the output
// register. Throughput: one item per cycle into the pipeline while in_ready_o
// is high; the single result port delivers one vertex per cycle while
// out_ready_i is high, so a two-sided item holds back the next item until
// both of its vertices are taken.
// Reset clears all valid state and loads unit inverse scales and zero lengths.
// When the receiver stalls, results hold, one item parks in the skid stage and
// the whole pipeline freezes on the next cycle; nothing is lost or repeated.
module bristle_vertex_offset_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  bvo_pkg::bvo_in_t   in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output bvo_pkg::bvo_out_t  out_data_o
);

  bvo_pkg::bvo_cfg_t  cfg_q;
  logic               pipe_v;
  bvo_pkg::bvo_pair_t pipe_d;
  logic               skid_full_d, skid_full_q;
  bvo_pkg::bvo_pair_t skid_q;
  logic               e_valid, e_ready;
  bvo_pkg::bvo_pair_t e_data;
  logic               top_d, top_q, und_d, und_q;
  bvo_pkg::bvo_pair_t ex_q;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.inv_xy    <= 31'd65536;
      cfg_q.inv_z     <= 31'd65536;
      cfg_q.top_len   <= '0;
      cfg_q.under_len <= '0;
    end else if (cfg_we_i) begin
      case (bvo_pkg::bvo_reg_e'(cfg_idx_i))
        bvo_pkg::REG_INV_XY:    cfg_q.inv_xy    <= cfg_data_i[30:0];
        bvo_pkg::REG_INV_Z:     cfg_q.inv_z     <= cfg_data_i[30:0];
        bvo_pkg::REG_TOP_LEN:   cfg_q.top_len   <= cfg_data_i;
        bvo_pkg::REG_UNDER_LEN: cfg_q.under_len <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Freeze the pipeline while the skid stage holds an item
  assign in_ready_o = ~skid_full_q;

  bvo_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (in_ready_o),
    .in_valid_i  (in_valid_i),
    .in_data_i   (in_data_i),
    .cfg_i       (cfg_q),
    .out_valid_o (pipe_v),
    .out_data_o  (pipe_d)
  );

  // Skid stage between pipeline and sequencer
  assign e_valid = skid_full_q | pipe_v;
  assign e_data  = skid_full_q ? skid_q : pipe_d;
  assign e_ready = ~(top_q | und_q) | (out_ready_i & ~(top_q & und_q));

  always_comb begin
    if (!skid_full_q) skid_full_d = pipe_v & ~e_ready;
    else              skid_full_d = ~e_ready;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_full_q <= 1'b0;
    end else begin
      skid_full_q <= skid_full_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!skid_full_q) skid_q <= pipe_d;
  end

  // Sequence the pending sides: drop each as it is taken, load the next item
  always_comb begin
    top_d = top_q;
    und_d = und_q;
    if (out_valid_o && out_ready_i) begin
      if (top_q) top_d = 1'b0;
      else       und_d = 1'b0;
    end
    if (e_valid && e_ready) begin
      top_d = (cfg_q.top_len != '0);
      und_d = (cfg_q.under_len != '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_q <= 1'b0;
      und_q <= 1'b0;
    end else begin
      top_q <= top_d;
      und_q <= und_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (e_valid && e_ready) ex_q <= e_data;
  end

  // Drive the result item
  assign out_valid_o           = top_q | und_q;
  assign out_data_o.vert_x     = top_q ? ex_q.vt[0] : ex_q.vu[0];
  assign out_data_o.vert_y     = top_q ? ex_q.vt[1] : ex_q.vu[1];
  assign out_data_o.vert_z     = top_q ? ex_q.vt[2] : ex_q.vu[2];
  assign out_data_o.is_under   = ~top_q;
  assign out_data_o.degenerate = ex_q.degen;
  assign out_data_o.last       = ~(top_q & und_q);

`ifndef SYNTHESIS
  // A result that is not the last of its item is always the top side
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.last |-> !out_data_o.is_under)
    else $error("non-last result on under side");

  // Taking a non-last top result leaves the under result waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !out_data_o.last |=> out_valid_o && out_data_o.is_under)
    else $error("under result lost after top result");

  // The skid stage only holds an item while a result is waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_full_q |-> out_valid_o)
    else $error("skid stage full with idle output");
`endif

endmodule
